/* src/bpfl_pkg.sv */
// shared types, constants and sizes for the buffer pool free list
package bpfl_pkg;

    localparam int ENTRIES = 64;
    localparam int SLOT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_BAKE  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        RES_DONE    = 2'd0,
        RES_EMPTY   = 2'd1,
        RES_IGNORED = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        SS_VACANT = 2'd0,
        SS_MAPPED = 2'd1,
        SS_BAKED  = 2'd2
    } slot_state_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    // one memory word per slot: its state and its vacant list link
    typedef struct packed {
        slot_state_t          st;
        logic [SLOT_W-1:0]    link;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

/* src/buffer_pool_free_list.sv */
// buffer pool allocator: lifo vacant list of slots kept in one ram
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  req     | req_valid, req_stall | op, slot_index
//  rsp     | rsp_valid, rsp_stall | status, granted_slot, vacant_count
//
// a request is accepted in the idle state, where the ram reads the slot word; in
// the execute state, once the response is free, the word is written back and the
// response register loaded; the single ram read port, being registered, sets this split
// reset: per slot valid flops are cleared, an entry never written reads as
// vacant and linked to the next slot, head is slot zero, all slots vacant
// a stalled response holds the request in the execute state until it drains
module buffer_pool_free_list (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  logic [1:0]                  op,
    input  logic [7:0]                  slot_index,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output logic [1:0]                  status,
    output logic [7:0]                  granted_slot,
    output logic [8:0]                  vacant_count
);

    localparam int SW = bpfl_pkg::SLOT_W;
    localparam int CW = bpfl_pkg::CNT_W;

    // control state
    bpfl_pkg::state_t               state_reg, state_next;
    logic [bpfl_pkg::ENTRIES-1:0]   valid_reg, valid_next;
    logic [SW-1:0]                  head_reg, head_next;
    logic [CW-1:0]                  total_reg, total_next;
    logic                           rsp_valid_reg, rsp_valid_next;

    // captured request
    logic [1:0]                     op_reg, op_next;
    logic                           in_range_reg, in_range_next;
    logic [SW-1:0]                  addr_reg, addr_next;

    // response payload
    logic [1:0]                     status_reg, status_next;
    logic [SW-1:0]                  granted_reg, granted_next;

    // ram interface
    logic                           ram_we;
    logic [SW-1:0]                  ram_raddr;
    logic [bpfl_pkg::ENTRY_W-1:0]   ram_rdata;
    bpfl_pkg::entry_t               wr_word;
    bpfl_pkg::entry_t               rd_word;
    bpfl_pkg::entry_t               cur_word;
    logic [SW-1:0]                  reset_link;

    logic                           accept;
    logic                           finish;
    logic                           rsp_free;

    bpfl_ram #(
        .WIDTH (bpfl_pkg::ENTRY_W),
        .DEPTH (bpfl_pkg::ENTRIES)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (wr_word),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_word = bpfl_pkg::entry_t'(ram_rdata);

    // an entry never written still holds its reset contents
    assign reset_link = (addr_reg == SW'(bpfl_pkg::ENTRIES - 1)) ? '0 : addr_reg + SW'(1);

    always_comb
    begin
        if (valid_reg[addr_reg])
        begin
            cur_word = rd_word;
        end
        else
        begin
            cur_word.st   = bpfl_pkg::SS_VACANT;
            cur_word.link = reset_link;
        end
    end

    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    // fsm next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bpfl_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = bpfl_pkg::ST_EXEC;
                end
            end
            bpfl_pkg::ST_EXEC:
            begin
                if (rsp_free)
                begin
                    state_next = bpfl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bpfl_pkg::ST_IDLE;
            end
        endcase
    end

    // fsm outputs
    always_comb
    begin
        req_stall = 1'b1;
        finish    = 1'b0;
        unique case (state_reg)
            bpfl_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
            end
            bpfl_pkg::ST_EXEC:
            begin
                finish = rsp_free;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    assign accept = req_valid && !req_stall;

    // read address: head for allocate, the named slot otherwise;
    // held from the captured request while executing
    always_comb
    begin
        op_next       = op_reg;
        in_range_next = in_range_reg;
        addr_next     = addr_reg;
        if (accept)
        begin
            op_next       = op;
            in_range_next = ({1'b0, slot_index} < 9'(bpfl_pkg::ENTRIES));
            addr_next     = (op == bpfl_pkg::OP_ALLOC) ? head_reg : slot_index[SW-1:0];
        end
    end

    assign ram_raddr = accept ? addr_next : addr_reg;

    // read-modify-write of the slot word
    always_comb
    begin
        ram_we       = 1'b0;
        wr_word      = cur_word;
        head_next    = head_reg;
        total_next   = total_reg;
        valid_next   = valid_reg;
        status_next  = status_reg;
        granted_next = granted_reg;
        if (finish)
        begin
            status_next  = bpfl_pkg::RES_IGNORED;
            granted_next = '0;
            unique case (op_reg)
                bpfl_pkg::OP_ALLOC:
                begin
                    if (total_reg == '0)
                    begin
                        status_next = bpfl_pkg::RES_EMPTY;
                    end
                    else
                    begin
                        // pop the head
                        ram_we       = 1'b1;
                        wr_word.st   = bpfl_pkg::SS_MAPPED;
                        head_next    = cur_word.link;
                        total_next   = total_reg - CW'(1);
                        status_next  = bpfl_pkg::RES_DONE;
                        granted_next = addr_reg;
                    end
                end
                bpfl_pkg::OP_FREE:
                begin
                    if (in_range_reg && cur_word.st != bpfl_pkg::SS_VACANT)
                    begin
                        // push onto the head
                        ram_we        = 1'b1;
                        wr_word.st    = bpfl_pkg::SS_VACANT;
                        wr_word.link  = head_reg;
                        head_next     = addr_reg;
                        total_next    = total_reg + CW'(1);
                        status_next   = bpfl_pkg::RES_DONE;
                    end
                end
                bpfl_pkg::OP_BAKE:
                begin
                    if (in_range_reg && cur_word.st == bpfl_pkg::SS_MAPPED)
                    begin
                        ram_we      = 1'b1;
                        wr_word.st  = bpfl_pkg::SS_BAKED;
                        status_next = bpfl_pkg::RES_DONE;
                    end
                end
                default:
                begin
                    status_next = bpfl_pkg::RES_IGNORED;
                end
            endcase
            if (ram_we)
            begin
                valid_next[addr_reg] = 1'b1;
            end
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (finish)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bpfl_pkg::ST_IDLE;
            valid_reg     <= '0;
            head_reg      <= '0;
            total_reg     <= CW'(bpfl_pkg::ENTRIES);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            head_reg      <= head_next;
            total_reg     <= total_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        in_range_reg <= in_range_next;
        addr_reg     <= addr_next;
        status_reg   <= status_next;
        granted_reg  <= granted_next;
    end

    // the count only moves when a response is loaded, so it tracks the
    // response register without a copy of its own
    assign rsp_valid    = rsp_valid_reg;
    assign status       = status_reg;
    assign granted_slot = 8'(granted_reg);
    assign vacant_count = 9'(total_reg);

endmodule

/* src/bpfl_ram.sv */
// generic single write port, single read port ram with registered read
module bpfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
